// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/ccc_pkg.sv =====
package ccc_pkg;

  localparam int MAX_CLUSTER_BYTES = 8192;
  localparam int MIN_CLUSTER_BYTES = 3;
  localparam int BYTE_W = 8;
  localparam int CNT_W = 14;
  localparam int CLS_W = 2;
  localparam int OUT_DATA_W = ((CLS_W + 2 * CNT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_DATA_W - CLS_W - 2 * CNT_W;

  localparam logic [CNT_W-1:0] RESET_CLUSTER_BYTES = CNT_W'(4096);
  localparam logic [CNT_W-1:0] RESET_PATTERN_THRESHOLD = CNT_W'(4);
  localparam logic [CNT_W-1:0] SIZE_MIN = CNT_W'(MIN_CLUSTER_BYTES);
  localparam logic [CNT_W-1:0] SIZE_MAX = CNT_W'(MAX_CLUSTER_BYTES);

  localparam logic [BYTE_W-1:0] CH_B = 8'h42;
  localparam logic [BYTE_W-1:0] CH_M = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_P = 8'h50;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h00;

  typedef enum logic [CLS_W-1:0] {
    CLS_DIR      = 2'd0,
    CLS_BMP_HEAD = 2'd1,
    CLS_BMP_DATA = 2'd2,
    CLS_UNUSED   = 2'd3
  } cls_t;

  typedef enum logic [0:0] {
    REG_CLUSTER_BYTES      = 1'b0,
    REG_PATTERN_THRESHOLD  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    cls_t             cls;
    logic [CNT_W-1:0] pattern_count;
    logic [CNT_W-1:0] zero_count;
  } result_t;

endpackage

// ===== sv/cluster_content_classifier_core.sv =====
// Classifies one disk cluster from its bytes, taken one item per cycle in order. The cluster
// length comes from cluster_bytes (held to 3..8192) and gives one result item after the last
// byte: class (directory, bitmap header, bitmap data, unused), the count of 'B','M','P'
// windows and the count of zero bytes in positions 0 to size-3. A byte passes through an input
// register and one stage of counter logic into the result register, so the block sustains one byte
// per cycle; it stalls only when a finished result is still waiting on the output and the byte in
// hand ends the next cluster. The user must write cfg registers between clusters; not enforced.
`include "assert_macros.svh"

module cluster_content_classifier_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ccc_pkg::BYTE_W-1:0]       s_tdata,   // data_byte[7:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ccc_pkg::OUT_DATA_W-1:0]   m_tdata,   // cluster_class, pattern_count, zero_count
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  ccc_pkg::cfg_reg_t                cfg_index,
  input  logic [ccc_pkg::CNT_W-1:0]        cfg_data
);

  ccc_pkg::in_item_t item;
  ccc_pkg::result_t  result;
  logic              done;
  logic              fire;

  assign cfg_ready = 1'b1;
  assign fire      = item.valid && (!m_tvalid || m_tready || !done);

  ccc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .fire     (fire),
    .item     (item)
  );

  ccc_stats u_stats (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .fire      (fire),
    .done      (done),
    .result    (result)
  );

  ccc_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && done),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `CCC_ASSERT_NEXT(a_result_follows, fire && done, m_tvalid)
  `CCC_ASSERT_NOW(a_ready_when_out_free, !m_tvalid, s_tready)
  `CCC_ASSERT_NOW(a_counts_bounded, m_tvalid,
    (m_tdata[15:2] <= ccc_pkg::CNT_W'(ccc_pkg::MAX_CLUSTER_BYTES - 2)) &&
    (m_tdata[29:16] <= ccc_pkg::CNT_W'(ccc_pkg::MAX_CLUSTER_BYTES - 2)))

endmodule

// ===== sv/ccc_in_reg.sv =====
module ccc_in_reg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [ccc_pkg::BYTE_W-1:0] s_tdata,
  input  logic                     fire,
  output ccc_pkg::in_item_t        item
);

  logic                       in_valid;
  logic [ccc_pkg::BYTE_W-1:0] in_byte;

  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  assign item.valid = in_valid;
  assign item.data  = in_byte;

endmodule

// ===== sv/ccc_stats.sv =====
module ccc_stats (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  ccc_pkg::cfg_reg_t         cfg_index,
  input  logic [ccc_pkg::CNT_W-1:0] cfg_data,
  input  ccc_pkg::in_item_t         item,
  input  logic                      fire,
  output logic                      done,
  output ccc_pkg::result_t          result
);

  logic [ccc_pkg::CNT_W-1:0]  cluster_bytes;
  logic [ccc_pkg::CNT_W-1:0]  pattern_threshold;
  logic [ccc_pkg::CNT_W-1:0]  byte_index;
  logic [ccc_pkg::BYTE_W-1:0] prev_byte;
  logic [ccc_pkg::BYTE_W-1:0] prev_prev_byte;
  logic [ccc_pkg::CNT_W-1:0]  match_counter;
  logic [ccc_pkg::CNT_W-1:0]  zero_counter;
  logic                       header_flag;

  logic [ccc_pkg::CNT_W-1:0]  size_eff;
  logic [ccc_pkg::CNT_W-1:0]  counted_len;
  logic                       hdr_hit;
  logic                       match_hit;
  logic                       zero_hit;
  logic [ccc_pkg::CNT_W-1:0]  match_counter_next;
  logic [ccc_pkg::CNT_W-1:0]  zero_counter_next;
  logic                       header_flag_next;
  ccc_pkg::cls_t              cls;

  always_comb begin
    priority if (cluster_bytes < ccc_pkg::SIZE_MIN) begin
      size_eff = ccc_pkg::SIZE_MIN;
    end else if (cluster_bytes > ccc_pkg::SIZE_MAX) begin
      size_eff = ccc_pkg::SIZE_MAX;
    end else begin
      size_eff = cluster_bytes;
    end
  end

  assign counted_len = size_eff - ccc_pkg::CNT_W'(2);
  assign done        = byte_index >= (size_eff - ccc_pkg::CNT_W'(1));

  assign hdr_hit   = (byte_index == ccc_pkg::CNT_W'(1)) && (prev_byte == ccc_pkg::CH_B)
                     && (item.data == ccc_pkg::CH_M);
  assign match_hit = (byte_index >= ccc_pkg::CNT_W'(2)) && (prev_prev_byte == ccc_pkg::CH_B)
                     && (prev_byte == ccc_pkg::CH_M) && (item.data == ccc_pkg::CH_P);
  assign zero_hit  = (byte_index < counted_len) && (item.data == ccc_pkg::CH_ZERO);

  assign match_counter_next = match_counter + ccc_pkg::CNT_W'(match_hit);
  assign zero_counter_next  = zero_counter + ccc_pkg::CNT_W'(zero_hit);
  assign header_flag_next   = header_flag || hdr_hit;

  always_comb begin
    priority if (header_flag_next) begin
      cls = ccc_pkg::CLS_BMP_HEAD;
    end else if (match_counter_next > pattern_threshold) begin
      cls = ccc_pkg::CLS_DIR;
    end else if (zero_counter_next == counted_len) begin
      cls = ccc_pkg::CLS_UNUSED;
    end else begin
      cls = ccc_pkg::CLS_BMP_DATA;
    end
  end

  assign result = '{cls: cls, pattern_count: match_counter_next,
                    zero_count: zero_counter_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_bytes     <= ccc_pkg::RESET_CLUSTER_BYTES;
      pattern_threshold <= ccc_pkg::RESET_PATTERN_THRESHOLD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ccc_pkg::REG_CLUSTER_BYTES:     cluster_bytes     <= cfg_data;
        ccc_pkg::REG_PATTERN_THRESHOLD: pattern_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index     <= '0;
      prev_byte      <= '0;
      prev_prev_byte <= '0;
      match_counter  <= '0;
      zero_counter   <= '0;
      header_flag    <= 1'b0;
    end else if (fire) begin
      if (done) begin
        byte_index     <= '0;
        prev_byte      <= '0;
        prev_prev_byte <= '0;
        match_counter  <= '0;
        zero_counter   <= '0;
        header_flag    <= 1'b0;
      end else begin
        byte_index     <= byte_index + ccc_pkg::CNT_W'(1);
        prev_byte      <= item.data;
        prev_prev_byte <= prev_byte;
        match_counter  <= match_counter_next;
        zero_counter   <= zero_counter_next;
        header_flag    <= header_flag_next;
      end
    end
  end

endmodule

// ===== sv/ccc_out_reg.sv =====
module ccc_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  ccc_pkg::result_t               result,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ccc_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic             res_valid;
  ccc_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= result;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {{ccc_pkg::OUT_PAD_W{1'b0}}, res.zero_count, res.pattern_count, res.cls};

endmodule
